// ----- hdl/trial_division_primality_test_defines.svh -----
// Assertion macros used by the RTL.
`ifndef TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH
`define TRIAL_DIVISION_PRIMALITY_TEST_DEFINES_SVH

`ifndef SYNTHESIS

// Property that must hold on every clock edge outside reset.
`define TDPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication: whenever ante holds, cons holds in the same cycle.
`define TDPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define TDPT_ASSERT(label, clk, rst, prop)
`define TDPT_ASSERT_IMPL(label, clk, rst, ante, cons)

`endif

`endif

// ----- hdl/tdpt_pkg.sv -----
`timescale 1ns / 1ps

package tdpt_pkg;

   // fixed width of the candidate port
   localparam int CANDIDATE_W = 32;

   // default datapath width
   localparam int WIDTH_DEFAULT = 32;

endpackage

// ----- hdl/trial_division_primality_test.sv -----
`timescale 1ns / 1ps
// Trial-division primality test. Takes one unsigned candidate per item and
// returns one item with is_prime set when the candidate is prime. Only the
// low WIDTH bits of the candidate are tested (zero-extended when WIDTH is
// above 32). Values below 2 and even values other than 2 are answered
// without any search. For an odd candidate the block first finds
// floor(sqrt(n)) bit by bit, one root digit per step, then tries every odd
// divisor d = 3, 5, ... up to that root; each divisor takes one bound check
// plus a WIDTH-step restoring division, remainder only. All of it runs
// through one shared subtract/compare unit. The input side is ready only
// while no item is in work; a finished result sits in the output register,
// and the next item is accepted while it waits to be taken.

`include "trial_division_primality_test_defines.svh"

module trial_division_primality_test
   import tdpt_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CANDIDATE_W-1:0] req_candidate,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_prime
);

   localparam int CntW = $clog2(WIDTH);
   // highest power of four that fits in WIDTH bits: first root digit
   localparam logic [WIDTH-1:0] BitInit = WIDTH'(1) << (2 * ((WIDTH - 1) / 2));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CHECK,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] n_ff, n_in;       // candidate under test
   logic [WIDTH-1:0] acc_ff, acc_in;   // root remainder, then division remainder
   logic [WIDTH-1:0] quo_ff, quo_in;   // dividend bits still to shift in
   logic [WIDTH-1:0] root_ff, root_in; // root being built, then the limit
   logic [WIDTH-1:0] bit_ff, bit_in;   // current root digit weight
   logic [WIDTH-1:0] d_ff, d_in;       // trial divisor
   logic [CntW-1:0]  cnt_ff, cnt_in;   // division step counter
   logic             res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_prime_ff, rsp_prime_in;

   // shared subtract / compare unit
   logic [WIDTH:0]   sub_a, sub_b;
   logic [WIDTH+1:0] sub_diff;
   logic             sub_ge;
   logic [WIDTH-1:0] cand;

   assign cand = WIDTH'(req_candidate);

   always_comb begin
      unique case (state_ff)
         ST_SQRT: begin
            sub_a = {1'b0, acc_ff};
            sub_b = {1'b0, root_ff} + {1'b0, bit_ff};
         end
         ST_CHECK: begin
            sub_a = {1'b0, root_ff};
            sub_b = {1'b0, d_ff};
         end
         ST_DIV: begin
            sub_a = {acc_ff, quo_ff[WIDTH-1]};
            sub_b = {1'b0, d_ff};
         end
         default: begin
            sub_a = '0;
            sub_b = '0;
         end
      endcase
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge   = ~sub_diff[WIDTH+1];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      quo_in       = quo_ff;
      root_in      = root_ff;
      bit_in       = bit_ff;
      d_in         = d_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_prime_in = rsp_prime_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in    = cand;
               acc_in  = cand;
               root_in = '0;
               bit_in  = BitInit;
               if (cand < WIDTH'(2)) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else if (cand == WIDTH'(2)) begin
                  res_in   = 1'b1;
                  state_in = ST_DONE;
               end else if (!cand[0]) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_SQRT;
               end
            end
         end
         ST_SQRT: begin
            // one root digit per cycle
            if (sub_ge) begin
               acc_in  = sub_diff[WIDTH-1:0];
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == WIDTH'(1)) begin
               d_in     = WIDTH'(3);
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // keep dividing while d <= root
            if (sub_ge) begin
               acc_in   = '0;
               quo_in   = n_ff;
               cnt_in   = CntW'(WIDTH - 1);
               state_in = ST_DIV;
            end else begin
               res_in   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            acc_in = sub_ge ? sub_diff[WIDTH-1:0] : sub_a[WIDTH-1:0];
            quo_in = quo_ff << 1;
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               if (acc_in == '0) begin
                  res_in   = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  d_in     = d_ff + WIDTH'(2);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff         <= n_in;
      acc_ff       <= acc_in;
      quo_ff       <= quo_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      d_ff         <= d_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_prime_ff;

   // root digit weight is a single power of four while the root is built
   `TDPT_ASSERT_IMPL(a_sqrt_bit_onehot, clock, reset, state_ff == ST_SQRT, $onehot(bit_ff))
   // trial divisors are odd and at least three
   `TDPT_ASSERT_IMPL(a_div_odd, clock, reset, state_ff == ST_DIV,
                     d_ff[0] && d_ff >= WIDTH'(3))
   // partial remainder stays below the divisor
   `TDPT_ASSERT_IMPL(a_rem_bound, clock, reset, state_ff == ST_DIV, acc_ff < d_ff)
   // only odd candidates of three or more reach trial division
   `TDPT_ASSERT_IMPL(a_odd_cand, clock, reset,
                     state_ff == ST_CHECK || state_ff == ST_DIV,
                     n_ff[0] && n_ff >= WIDTH'(3))

endmodule

// ----- tb/prime_result_checker.sv -----
`timescale 1ns / 1ps

module prime_result_checker
   import tdpt_pkg::*;
#(
   parameter int WIDTH = WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [CANDIDATE_W-1:0] req_candidate,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_is_prime,
   output int                     failures,
   output int                     outstanding
);

   typedef struct {
      logic [CANDIDATE_W-1:0] candidate;
      logic                   is_prime;
   } verdict_type;

   verdict_type pending_verdicts [$];

   // odd divisors up to the root; d*d fits easily in 64 bits
   function automatic logic expect_prime(input logic [CANDIDATE_W-1:0] cand);
      logic [63:0] n;
      logic [63:0] d;
      n = 64'(cand);
      if (WIDTH < 64)
         n = n & ((64'd1 << WIDTH) - 64'd1);
      if (n < 64'd2)
         return 1'b0;
      if (n == 64'd2)
         return 1'b1;
      if (!n[0])
         return 1'b0;
      for (d = 64'd3; d * d <= n; d = d + 64'd2) begin
         if (n % d == 64'd0)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   initial begin
      failures = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      verdict_type head;
      verdict_type fresh;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_verdicts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual is_prime=%0b",
                        $time, rsp_is_prime);
               failures <= failures + 1;
            end else begin
               head = pending_verdicts.pop_front();
               if (rsp_is_prime !== head.is_prime) begin
                  $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                           $time, head.candidate, head.is_prime, rsp_is_prime);
                  failures <= failures + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            fresh.candidate = req_candidate;
            fresh.is_prime  = expect_prime(req_candidate);
            pending_verdicts.push_back(fresh);
         end
         outstanding <= pending_verdicts.size();
      end
   end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the trial-division primality block. The checker
// beside the block watches both channels, predicts every verdict and counts
// mismatches; this module only makes items, shapes the handshakes and
// decides pass or fail.
module tb;
   import tdpt_pkg::*;

   // Slowest item used here is the largest prime below 2**24; everything
   // else is far shorter, so this limit leaves a wide margin.
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE       = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CANDIDATE_W-1:0] req_candidate;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_is_prime;

   int send_idle_pct;
   int recv_idle_pct = 45;
   int hold_requests = 0;   // bumped by stimulus
   int holds_served  = 0;   // followed by the receiver
   int hold_left     = 0;
   int cycle_count   = 0;
   int failures;
   int outstanding;

   trial_division_primality_test dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime)
   );

   prime_result_checker result_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_candidate(req_candidate),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_is_prime (rsp_is_prime),
      .failures     (failures),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random back-pressure, plus a long hold-off on request. The
   // hold is counted here so the sender can keep pushing meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Offer one item. Valid only drops when the sender decides to idle, so
   // back-to-back items keep it high with no glitch in between.
   task automatic offer(input logic [CANDIDATE_W-1:0] value);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_candidate <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending and wait until every predicted verdict has come back,
   // then let the block settle so that any stray result shows.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Most items are small so the divisor search stays short. Wide values
   // are forced onto a multiple of a small number: they still toggle every
   // upper bit but exit the search after a handful of divisors.
   function automatic logic [CANDIDATE_W-1:0] draw_candidate();
      int unsigned            kind;
      int unsigned            factor;
      logic [CANDIDATE_W-1:0] value;
      kind = $urandom_range(9);
      if (kind < 5)
         return CANDIDATE_W'($urandom_range(4095));
      if (kind < 7)
         return CANDIDATE_W'($urandom_range(65535));
      value  = $urandom;
      factor = $urandom_range(13, 2);
      return value - (value % factor);
   endfunction

   initial begin
      logic [CANDIDATE_W-1:0] directed_set [$];
      directed_set = '{
         // below two, two itself, smallest odd prime, first even composite
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5,
         // squares of odd primes: the root itself is the only divisor
         32'd9, 32'd25, 32'd49, 32'd121, 32'd1042441,
         32'd15, 32'd97,
         // largest 16-bit prime, first prime past 16 bits, its multiple
         32'd65521, 32'd65537, 32'd196611,
         // largest prime below 2**24: full divisor sweep
         32'd16777213,
         // wide patterns and the top of the range
         32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
         32'hFFFF_FFFE, 32'hFFFF_FFFF
      };

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_candidate = '0;
      send_idle_pct = 9;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // phase one: light sender gaps, heavy receiver stalls
      foreach (directed_set[i])
         offer(directed_set[i]);
      repeat (24) offer(draw_candidate());
      drain();

      // phase two: the other way round
      send_idle_pct = 45;
      recv_idle_pct <= 9;
      repeat (24) offer(draw_candidate());
      drain();

      // phase three: no idling; open with a long receiver hold so the
      // output register fills and the block stops taking items
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_requests <= hold_requests + 1;
      repeat (8) offer(CANDIDATE_W'($urandom_range(200)));
      repeat (22) offer(draw_candidate());
      drain();

      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
